### design/bbr_pkg.sv
`timescale 1ns / 1ps

package bbr_pkg;

  localparam int unsigned NUM_PORTS_DEF = 16;
  localparam int unsigned PORT_W        = 4;
  localparam int unsigned SWITCH_W      = 3;

  typedef logic [PORT_W-1:0]   port_t;
  typedef logic [SWITCH_W-1:0] switch_t;

  typedef struct packed {
    port_t dest_port;
    logic  last_request;
  } bbr_in_t;

  typedef struct packed {
    port_t   sorted_input;
    port_t   route_dest;
    switch_t stage_a_switch;
    switch_t stage_b_switch;
    switch_t stage_c_switch;
    switch_t stage_d_switch;
    port_t   exit_port;
    logic    overflow_seen;
    logic    last_route;
  } bbr_out_t;

  // Command broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic  load;
    logic  shift;
    port_t dest;
  } bbr_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } bbr_state_e;

endpackage

### design/bbr_cell.sv
`timescale 1ns / 1ps

module bbr_cell (
  input  logic             clk_i,
  input  bbr_pkg::bbr_ctl_t ctl_i,
  input  logic             occupied_i,
  input  logic             prev_gt_i,
  input  bbr_pkg::port_t   prev_val_i,
  input  bbr_pkg::port_t   next_val_i,
  output bbr_pkg::port_t   val_o,
  output logic             gt_o
);
  import bbr_pkg::*;

  port_t val_q;
  port_t val_d;

  // An empty cell counts as larger than any destination.
  assign gt_o = !occupied_i || (val_q > ctl_i.dest);

  always_comb begin
    val_d = val_q;
    if (ctl_i.load && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : ctl_i.dest;
    end else if (ctl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

### design/batcher_banyan_route_16.sv
`timescale 1ns / 1ps

// Batcher-banyan self-routing switch model for NUM_PORTS input cells.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one
// destination port per beat. Each accepted beat is inserted into a chain
// of sorting cells, so the chain always holds the batch in ascending order.
// A beat with last_request closes the batch. Beats beyond NUM_PORTS are
// dropped and reported through overflow_seen on every route of the batch.
// After the closing beat the chain shifts toward cell zero once per output
// beat, and each popped destination is traced through the four banyan
// stages to give one route on the output channel (out_valid_o, out_stall_i,
// out_data_o). While loading, the input takes a destination whenever one is
// valid, and the output gives one route per cycle when the receiver does
// not stall; a batch is loaded in full before its first route is emitted.
// After the closing beat is accepted the state register moves to emitting,
// and the first route is then captured in the output register. The input is
// stalled while routes are emitted. When the receiver stalls, the output
// register holds its beat and the chain waits. Reset clears the counters,
// the overflow flag and the output valid; the cell contents are not reset
// and are only read once loaded.
module batcher_banyan_route_16 #(
  parameter int unsigned NUM_PORTS = bbr_pkg::NUM_PORTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbr_pkg::bbr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bbr_pkg::bbr_out_t out_data_o
);
  import bbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_PORTS + 1);

  bbr_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] emit_q, emit_d;
  logic             dropped_q, dropped_d;
  logic             out_valid_q, out_valid_d;
  bbr_out_t         out_q, out_d;

  logic     in_take;
  logic     pop;
  logic     full;
  logic     last_pop;
  bbr_ctl_t ctl;

  port_t cell_val [NUM_PORTS];
  logic  cell_gt  [NUM_PORTS];

  assign full     = (count_q == CNT_W'(NUM_PORTS));
  assign in_take  = in_valid_i && !in_stall_o;
  assign last_pop = (CNT_W'(emit_q + 1'b1) == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_take && in_data_i.last_request) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pop && last_pop) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    pop        = 1'b0;
    unique case (state_q)
      ST_LOAD: in_stall_o = 1'b0;
      ST_EMIT: pop = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign ctl.load  = in_take && !full;
  assign ctl.shift = pop;
  assign ctl.dest  = in_data_i.dest_port;

  // The sorting chain: each cell sees its left neighbor on insert and its
  // right neighbor while emitting.
  for (genvar k = 0; k < NUM_PORTS; k++) begin : g_cell
    logic  prev_gt;
    port_t prev_val;
    port_t next_val;
    if (k == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_mid
      assign prev_gt  = cell_gt[k-1];
      assign prev_val = cell_val[k-1];
    end
    if (k == NUM_PORTS - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[k+1];
    end

    bbr_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occupied_i (CNT_W'(k) < count_q),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (cell_val[k]),
      .gt_o       (cell_gt[k])
    );
  end

  // Trace the destination at the head of the chain through the banyan.
  always_comb begin
    port_t   v;
    switch_t a, b, c, d;
    v = cell_val[0];
    a = switch_t'(emit_q);
    b = {v[3], a[1:0]};
    c = {b[2], v[2], b[0]};
    d = {c[2:1], v[1]};
    out_d.sorted_input   = port_t'(emit_q);
    out_d.route_dest     = v;
    out_d.stage_a_switch = a;
    out_d.stage_b_switch = b;
    out_d.stage_c_switch = c;
    out_d.stage_d_switch = d;
    out_d.exit_port      = {d, v[0]};
    out_d.overflow_seen  = dropped_q;
    out_d.last_route     = last_pop;
  end

  always_comb begin
    count_d     = count_q;
    emit_d      = emit_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_take) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = CNT_W'(count_q + 1'b1);
      end
    end
    if (pop) begin
      out_valid_d = 1'b1;
      if (last_pop) begin
        count_d   = '0;
        emit_d    = '0;
        dropped_d = 1'b0;
      end else begin
        emit_d = CNT_W'(emit_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      emit_q      <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emit_q      <= emit_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/bbr_checker.sv
`timescale 1ns / 1ps

module bbr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input bbr_pkg::bbr_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bbr_pkg::bbr_out_t out_data_o
);
  import bbr_pkg::*;

  logic out_mid;

  assign out_mid = out_valid_o && !out_stall_i && !out_data_o.last_route;

  // A stalled route stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("route changed while stalled");

  // Closing a batch stops further loads until the routes are out.
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_request |=> in_stall_o)
    else $error("input taken right after batch close");

  // Routes of one batch follow back to back with rising input positions.
  a_next_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mid |=> out_valid_o &&
      (out_data_o.sorted_input == port_t'($past(out_data_o.sorted_input) + 1'b1)))
    else $error("route sequence broken");

  // Destinations leave the sorter in ascending order.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mid |=> out_data_o.route_dest >= $past(out_data_o.route_dest))
    else $error("destinations out of order");

endmodule

bind batcher_banyan_route_16 bbr_checker u_bbr_checker (.*);
